/* src/chd_pkg.sv */
// Shared types, constants and helpers for the chunked body decoder.
// No dependencies; chd_step and the top level refer to this package by scoped name.
package chd_pkg;

	// Width of the chunk size and body length counters
	localparam int LEN_W = 32;
	// Width of the body limit compare: one carry bit over the length, at least the register
	localparam int SUM_W = (LEN_W + 1 > 32) ? LEN_W + 1 : 33;
	localparam int TRL_W = 16;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// Input operation codes
	localparam logic OP_DATA    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// Register indexes on the configuration port
	localparam logic REG_MAX_BODY    = 1'b0;
	localparam logic REG_MAX_TRAILER = 1'b1;

	localparam logic [31:0]      MAX_BODY_RST    = 32'hFFFF_FFFF;
	localparam logic [TRL_W-1:0] MAX_TRAILER_RST = 16'd8192;

	typedef enum logic [6:0] {
		PH_SIZE     = 7'b000_0001,
		PH_DISCARD  = 7'b000_0010,
		PH_DATA     = 7'b000_0100,
		PH_ENDLINE  = 7'b000_1000,
		PH_TRAILER  = 7'b001_0000,
		PH_COMPLETE = 7'b010_0000,
		PH_ERROR    = 7'b100_0000
	} phase_t;

	typedef enum logic {
		FAIL_BAD_REQUEST = 1'b0,
		FAIL_TOO_LARGE   = 1'b1
	} fail_t;

	typedef struct packed {
		phase_t             phase;
		phase_t             after_line;
		logic [LEN_W-1:0]   chunk_rem;
		logic [LEN_W-1:0]   body_len;
		logic               digit_seen;
		logic               pending_cr;
		logic               line_empty;
		logic [TRL_W-1:0]   trailer_cnt;
		fail_t              fail_reason;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:       PH_SIZE,
		after_line:  PH_SIZE,
		chunk_rem:   '0,
		body_len:    '0,
		digit_seen:  1'b0,
		pending_cr:  1'b0,
		line_empty:  1'b1,
		trailer_cnt: '0,
		fail_reason: FAIL_BAD_REQUEST
	};

	typedef struct packed {
		logic [31:0]      max_body;
		logic [TRL_W-1:0] max_trailer;
	} cfg_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       complete;
		logic       failed;
		logic       fail_code;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	// ASCII hex digit decode
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h = '0;
		if (c >= "0" && c <= "9") begin
			h.valid = 1'b1;
			h.value = 4'(c - 8'h30);
		end else if (c >= "a" && c <= "f") begin
			h.valid = 1'b1;
			h.value = 4'(c - 8'h57);
		end else if (c >= "A" && c <= "F") begin
			h.valid = 1'b1;
			h.value = 4'(c - 8'h37);
		end
		return h;
	endfunction

endpackage

/* src/chd_if.sv */
// Valid/ready channel interfaces for the decoder: byte stream in, results out.
// Depends on nothing but the port widths fixed here.
interface chd_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;

	modport source (output valid, op, data_byte, input ready);
	modport sink   (input valid, op, data_byte, output ready);
endinterface

interface chd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       complete;
	logic       failed;
	logic       fail_code;

	modport source (output valid, payload_byte, payload_valid, complete, failed, fail_code,
		input ready);
	modport sink   (input valid, payload_byte, payload_valid, complete, failed, fail_code,
		output ready);
endinterface

/* src/chd_step.sv */
// Per-byte next-state and result logic of the chunked body decoder.
// Depends on chd_pkg for the state, config and result types.
module chd_step (
	input  chd_pkg::state_t  cur,
	input  chd_pkg::cfg_t    cfg,
	input  logic             op,
	input  logic [7:0]       data_byte,
	output chd_pkg::state_t  nxt,
	output chd_pkg::result_t res
);

	chd_pkg::hex_t               hex;
	logic [chd_pkg::SUM_W-1:0]   len_sum;
	logic                        size_ovf;
	logic                        over_limit;

	assign hex = chd_pkg::hex_decode(data_byte);

	// Running body length plus chunk size; shared by the size check and the body limit
	assign len_sum    = chd_pkg::SUM_W'(cur.body_len) + chd_pkg::SUM_W'(cur.chunk_rem);
	assign size_ovf   = len_sum[chd_pkg::LEN_W];
	assign over_limit = len_sum > chd_pkg::SUM_W'(cfg.max_body);

	always_comb begin
		nxt = cur;
		res = '0;
		if (op == chd_pkg::OP_RESTART) begin
			nxt = chd_pkg::STATE_RESET;
		end else begin
			unique case (cur.phase)
				chd_pkg::PH_SIZE: begin
					if (hex.valid) begin
						// top nibble busy: one more digit would overflow
						if (cur.chunk_rem[chd_pkg::LEN_W-1 -: 4] != 4'h0) begin
							nxt.phase       = chd_pkg::PH_ERROR;
							nxt.fail_reason = chd_pkg::FAIL_BAD_REQUEST;
						end else begin
							nxt.chunk_rem  = {cur.chunk_rem[chd_pkg::LEN_W-5:0], hex.value};
							nxt.digit_seen = 1'b1;
						end
					end else if (!cur.digit_seen || size_ovf) begin
						nxt.phase       = chd_pkg::PH_ERROR;
						nxt.fail_reason = chd_pkg::FAIL_BAD_REQUEST;
					end else begin
						// terminator is the first byte of the discarded line
						nxt.digit_seen = 1'b0;
						nxt.after_line = (cur.chunk_rem == '0) ? chd_pkg::PH_TRAILER
							: chd_pkg::PH_DATA;
						nxt.phase      = chd_pkg::PH_DISCARD;
						nxt.pending_cr = (data_byte == chd_pkg::CH_CR);
					end
				end
				chd_pkg::PH_DISCARD: begin
					if (cur.pending_cr && data_byte == chd_pkg::CH_LF) begin
						nxt.pending_cr = 1'b0;
						nxt.phase      = cur.after_line;
					end else begin
						nxt.pending_cr = (data_byte == chd_pkg::CH_CR);
					end
				end
				chd_pkg::PH_DATA: begin
					if (over_limit) begin
						nxt.phase       = chd_pkg::PH_ERROR;
						nxt.fail_reason = chd_pkg::FAIL_TOO_LARGE;
					end else begin
						res.payload_byte  = data_byte;
						res.payload_valid = 1'b1;
						nxt.body_len      = cur.body_len + chd_pkg::LEN_W'(1);
						nxt.chunk_rem     = cur.chunk_rem - chd_pkg::LEN_W'(1);
						if (cur.chunk_rem == chd_pkg::LEN_W'(1)) begin
							nxt.phase      = chd_pkg::PH_ENDLINE;
							nxt.after_line = chd_pkg::PH_SIZE;
							nxt.pending_cr = 1'b0;
						end
					end
				end
				chd_pkg::PH_ENDLINE: begin
					if (cur.pending_cr) begin
						if (data_byte == chd_pkg::CH_LF) begin
							nxt.pending_cr = 1'b0;
							nxt.phase      = cur.after_line;
						end else begin
							nxt.phase       = chd_pkg::PH_ERROR;
							nxt.fail_reason = chd_pkg::FAIL_BAD_REQUEST;
						end
					end else if (data_byte == chd_pkg::CH_CR) begin
						nxt.pending_cr = 1'b1;
					end else begin
						nxt.phase       = chd_pkg::PH_ERROR;
						nxt.fail_reason = chd_pkg::FAIL_BAD_REQUEST;
					end
				end
				chd_pkg::PH_TRAILER: begin
					if (cur.trailer_cnt >= cfg.max_trailer) begin
						nxt.phase       = chd_pkg::PH_ERROR;
						nxt.fail_reason = chd_pkg::FAIL_BAD_REQUEST;
					end else begin
						nxt.trailer_cnt = cur.trailer_cnt + chd_pkg::TRL_W'(1);
						if (cur.pending_cr && data_byte == chd_pkg::CH_LF) begin
							nxt.pending_cr = 1'b0;
							if (cur.line_empty) begin
								nxt.phase = chd_pkg::PH_COMPLETE;
							end else begin
								nxt.line_empty = 1'b1;
							end
						end else if (data_byte == chd_pkg::CH_CR) begin
							// a CR after CR makes the line non-empty
							if (cur.pending_cr) begin
								nxt.line_empty = 1'b0;
							end
							nxt.pending_cr = 1'b1;
						end else begin
							nxt.pending_cr = 1'b0;
							nxt.line_empty = 1'b0;
						end
					end
				end
				chd_pkg::PH_COMPLETE, chd_pkg::PH_ERROR: begin
					// sticky until restart
				end
				default: begin
					nxt = chd_pkg::STATE_RESET;
				end
			endcase
		end

		res.complete  = (nxt.phase == chd_pkg::PH_COMPLETE);
		res.failed    = (nxt.phase == chd_pkg::PH_ERROR);
		res.fail_code = res.failed ? nxt.fail_reason : 1'b0;
	end

endmodule

/* src/http_chunked_body_decoder.sv */
// Top level of the HTTP chunked body decoder: channels, APB registers, pipeline.
// Depends on chd_pkg, the chd_in_if / chd_out_if interfaces and chd_step.
//
// Usage:
//   byte_in carries one transaction per stream byte: op (0 = data byte, 1 = restart)
//   and data_byte. result_out returns exactly one transaction per input transaction:
//   the decoded payload byte with its valid flag, and the sticky complete / failed /
//   fail_code status as it stands after that byte.
//   A result passes the input register, then the result register fed by the
//   per-byte state update, and is offered from the result register.
//   Throughput: one byte per cycle while result_out does not stall; the state
//   update for a byte is combinational between the input and result registers.
//   When result_out stalls, one further byte is taken into the input register and
//   then byte_in.ready drops until the result register is emptied.
//   Reset clears the decoder state and in-flight transactions, and sets
//   max_body_size to all ones and max_trailer_size to 8192. A restart op clears the
//   state but keeps the registers.
//   Registers: max_body_size at 0x0 (32 bit), max_trailer_size at 0x4 (16 bit);
//   write them only while the decoder is idle.
module http_chunked_body_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	chd_in_if.sink      byte_in,
	chd_out_if.source   result_out
);

	chd_pkg::cfg_t    cfg_q;
	chd_pkg::state_t  state_q;
	chd_pkg::state_t  state_nxt;
	chd_pkg::result_t res_nxt;
	chd_pkg::result_t res_q;
	logic             out_valid_q;
	logic             valid_s1;
	logic             op_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             cfg_wr;

	// APB register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_body    <= chd_pkg::MAX_BODY_RST;
			cfg_q.max_trailer <= chd_pkg::MAX_TRAILER_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == chd_pkg::REG_MAX_BODY) begin
				cfg_q.max_body <= pwdata;
			end else begin
				cfg_q.max_trailer <= pwdata[chd_pkg::TRL_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == chd_pkg::REG_MAX_TRAILER) begin
			prdata = {{(32 - chd_pkg::TRL_W){1'b0}}, cfg_q.max_trailer};
		end else begin
			prdata = cfg_q.max_body;
		end
	end

	// Pipeline flow: stage 1 moves on whenever the result register is free
	assign advance       = valid_s1 && (!out_valid_q || result_out.ready);
	assign byte_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			op_s1   <= byte_in.op;
			byte_s1 <= byte_in.data_byte;
		end
	end

	chd_step u_step (
		.cur       (state_q),
		.cfg       (cfg_q),
		.op        (op_s1),
		.data_byte (byte_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chd_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.payload_byte  = res_q.payload_byte;
	assign result_out.payload_valid = res_q.payload_valid;
	assign result_out.complete      = res_q.complete;
	assign result_out.failed        = res_q.failed;
	assign result_out.fail_code     = res_q.fail_code;

`ifndef NO_ASSERTIONS
	// A full input stage facing a stalled result register must hold off new bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !result_out.ready) |-> !byte_in.ready)
	else $error("byte accepted while both stages are blocked");

	// A processed restart always leaves the decoder waiting for size digits
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == chd_pkg::OP_RESTART) |=> (state_q.phase == chd_pkg::PH_SIZE))
	else $error("restart did not return the decoder to the size phase");

	// A payload byte is never reported together with a final status
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_out.payload_valid) |-> (!result_out.failed && !result_out.complete))
	else $error("payload byte reported with complete or failed status");
`endif

endmodule
